>>> rtl/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants of the contrast stretch block: pixel and
// result words, sequencer states and the control words of the divide and
// square root unit.
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

    // pixel and result formats
    localparam int PIX_W   = 16;
    localparam int OUT_W   = 8;
    localparam int OUT_MAX = 255;

    // fixed point formats of the frame statistics
    localparam int FRAC_W     = 16;          // fraction bits of mean and deviation
    localparam int MSQ_FRAC_W = 2 * FRAC_W;  // fraction bits of mean square
    localparam int MEAN_W     = PIX_W + FRAC_W;
    localparam int MSQ_W      = 2 * MEAN_W;
    localparam int ROOT_W     = MEAN_W;
    localparam int DENOM_W    = MEAN_W + 2;
    localparam int GAIN_W     = 40;

    // shared multiplier operand width
    localparam int MUL_W = 32;

    // default configuration
    localparam int MAX_PIXELS_DEF     = 16777216;
    localparam int GAIN_FRAC_BITS_DEF = 24;
    localparam int DVD_W_DEF          = 89;
    localparam int DVS_W_DEF          = 34;

    // one input word
    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] pixel_value;
        logic             last_pixel;
    } t_in_word;

    // one result word
    typedef struct packed {
        logic [OUT_W-1:0] scaled_pixel;
        logic             flat_frame;
    } t_out_word;

    // operations of the divide and square root unit
    typedef enum logic [0:0] {
        UOP_DIV,
        UOP_SQRT
    } t_unit_op;

    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_rsp;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_ACC,
        ST_FIN,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_MSQ_GO,
        ST_MSQ_WAIT,
        ST_MSQ_MUL,
        ST_VAR,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DENOM,
        ST_GAIN_GO,
        ST_GAIN_WAIT,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/scs_div_sqrt.sv
// ----------------------------------------------------------------------------
// scs_div_sqrt
// Bit-serial restoring divider and square root sharing one subtractor.
// Division retires one quotient bit per cycle for its DVD_W quotient bits,
// the root one result bit per cycle for its ROOT_W result bits.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_div_sqrt #(
    parameter int DVD_W  = scs_pkg::DVD_W_DEF,
    parameter int DVS_W  = scs_pkg::DVS_W_DEF,
    parameter int ROOT_W = scs_pkg::ROOT_W
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire scs_pkg::t_unit_req i_req,
    input  wire logic [DVD_W-1:0]   i_dividend,
    input  wire logic [DVS_W-1:0]   i_divisor,
    output scs_pkg::t_unit_rsp      o_rsp,
    output logic      [DVD_W-1:0]   o_quotient,
    output logic      [ROOT_W-1:0]  o_root
);

    localparam int REM_W = ((DVS_W > ROOT_W + 2) ? DVS_W : ROOT_W + 2) + 1;
    localparam int RAD_W = 2 * ROOT_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    scs_pkg::t_unit_op   r_op;
    logic [REM_W-1:0]    r_rem;
    logic [DVD_W-1:0]    r_dvd;
    logic [DVS_W-1:0]    r_dvs;
    logic [ROOT_W-1:0]   r_root;

    logic [REM_W-1:0]    w_a;
    logic [REM_W-1:0]    w_b;
    logic [REM_W:0]      w_diff;
    logic                w_ge;

    // trial operands: next dividend bit or next radicand bit pair
    always_comb begin
        case (r_op)
            scs_pkg::UOP_SQRT: begin
                w_a = {r_rem[REM_W-3:0], r_dvd[DVD_W-1 -: 2]};
                w_b = REM_W'({r_root, 2'b01});
            end
            default: begin
                w_a = {r_rem[REM_W-2:0], r_dvd[DVD_W-1]};
                w_b = REM_W'(r_dvs);
            end
        endcase
    end

    // shared trial subtraction
    assign w_diff = {1'b0, w_a} - {1'b0, w_b};
    assign w_ge   = ~w_diff[REM_W];

    // step counter and handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                if (i_req.op == scs_pkg::UOP_SQRT) begin
                    r_cnt <= CNT_W'(ROOT_W);
                end else begin
                    r_cnt <= CNT_W'(DVD_W);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand load and one bit per step
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op   <= i_req.op;
            r_dvs  <= i_divisor;
            r_rem  <= '0;
            r_root <= '0;
            if (i_req.op == scs_pkg::UOP_SQRT) begin
                r_dvd <= i_dividend << (DVD_W - RAD_W);
            end else begin
                r_dvd <= i_dividend;
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[REM_W-1:0] : w_a;
            case (r_op)
                scs_pkg::UOP_SQRT: begin
                    r_dvd  <= {r_dvd[DVD_W-3:0], 2'b00};
                    r_root <= {r_root[ROOT_W-2:0], w_ge};
                end
                default: begin
                    r_dvd <= {r_dvd[DVD_W-2:0], w_ge};
                end
            endcase
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_quotient = r_dvd;
    assign o_root     = r_root;

endmodule

`default_nettype wire

>>> rtl/stddev_contrast_stretch.sv
// ----------------------------------------------------------------------------
// stddev_contrast_stretch
// Two pass linear stretch of one 16-bit channel to 8 bits, gain taken from
// the frame maximum, mean and population deviation.
// ----------------------------------------------------------------------------
// A statistics word is accepted, squared on the shared multiplier and
// accumulated; a scale word is accepted, multiplied as two 32-bit partial
// products of the 40-bit gain, rounded and registered once the output
// register is free or draining. A new word enters only when the last is
// through. The word flagged last_pixel adds the frame end work (mean, mean
// square, root, gain) on the bit-serial divide and root unit, DVD_W = 89 and
// ROOT_W = 32 by default; no word is accepted meanwhile. Results leave
// through an output register, so the next word is taken while a result waits.
`default_nettype none

module stddev_contrast_stretch #(
    parameter int MAX_PIXELS     = scs_pkg::MAX_PIXELS_DEF,
    parameter int GAIN_FRAC_BITS = scs_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire scs_pkg::t_in_word i_in_data,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output scs_pkg::t_out_word     o_out_data,
    input  wire logic              i_out_stall
);

    localparam int PIX_W   = scs_pkg::PIX_W;
    localparam int FRAC_W  = scs_pkg::FRAC_W;
    localparam int MUL_W   = scs_pkg::MUL_W;
    localparam int MUL_P_W = 2 * MUL_W;
    localparam int GAIN_W  = scs_pkg::GAIN_W;
    localparam int DENOM_W = scs_pkg::DENOM_W;
    localparam int OUT_W   = scs_pkg::OUT_W;

    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W  = PIX_W + CNT_W;
    localparam int SQ_W   = 2 * PIX_W + CNT_W;
    localparam int NUM_W  = ((GAIN_FRAC_BITS + FRAC_W + 8 > DENOM_W) ?
                             GAIN_FRAC_BITS + FRAC_W + 8 : DENOM_W) + 1;
    localparam int DVD_A  = SQ_W + scs_pkg::MSQ_FRAC_W;
    localparam int DVD_B  = (NUM_W > 2 * scs_pkg::ROOT_W) ? NUM_W : 2 * scs_pkg::ROOT_W;
    localparam int DVD_W  = (DVD_A > DVD_B) ? DVD_A : DVD_B;
    localparam int DVS_W  = (CNT_W > DENOM_W) ? CNT_W : DENOM_W;
    localparam int PROD_W = PIX_W + GAIN_W;

    localparam logic [NUM_W-1:0]  GAIN_NUM   =
        NUM_W'(scs_pkg::OUT_MAX) << (GAIN_FRAC_BITS + FRAC_W);
    localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W + 1)'(1) << (GAIN_FRAC_BITS - 1);

    // sequencer
    scs_pkg::t_state             r_state;
    scs_pkg::t_state             n_state;

    // frame statistics and latched gain
    logic [CNT_W-1:0]            r_count;
    logic [SUM_W-1:0]            r_sum;
    logic [SQ_W-1:0]             r_sq;
    logic [PIX_W-1:0]            r_min;
    logic [PIX_W-1:0]            r_max;
    logic [PIX_W-1:0]            r_offset;
    logic [GAIN_W-1:0]           r_gain;
    logic                        r_flat;

    // working registers
    logic [PIX_W-1:0]            r_pix;
    logic                        r_last;
    logic [scs_pkg::MEAN_W-1:0]  r_mean;
    logic [scs_pkg::MSQ_W-1:0]   r_var;
    logic [DENOM_W-1:0]          r_denom;
    logic [MUL_P_W-1:0]          r_mul;
    logic [PROD_W-1:0]           r_plo;
    logic                        r_out_valid;
    scs_pkg::t_out_word          r_out_data;

    // control
    logic                        w_in_stall;
    logic                        w_in_acc;
    logic                        w_mul_en;
    logic                        w_clear;
    logic                        w_out_load;
    scs_pkg::t_unit_req          w_unit_req;
    scs_pkg::t_unit_rsp          w_unit_rsp;

    // datapath
    logic [DVD_W-1:0]            w_unit_dvd;
    logic [DVS_W-1:0]            w_unit_dvs;
    logic [DVD_W-1:0]            w_unit_q;
    logic [scs_pkg::ROOT_W-1:0]  w_unit_root;
    logic [MUL_W-1:0]            w_mul_a;
    logic [MUL_W-1:0]            w_mul_b;
    logic [MUL_P_W-1:0]          w_mul_p;
    logic [PIX_W-1:0]            w_diff;
    logic [PROD_W-1:0]           w_prod;
    logic [PROD_W:0]             w_round;
    logic                        w_out_sat;
    logic                        w_gain_sat;

    // divide and square root unit
    scs_div_sqrt #(
        .DVD_W  (DVD_W),
        .DVS_W  (DVS_W),
        .ROOT_W (scs_pkg::ROOT_W)
    ) u_div_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_unit_req),
        .i_dividend (w_unit_dvd),
        .i_divisor  (w_unit_dvs),
        .o_rsp      (w_unit_rsp),
        .o_quotient (w_unit_q),
        .o_root     (w_unit_root)
    );

    assign w_in_acc = i_in_valid & ~w_in_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            scs_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = i_in_data.func ? scs_pkg::ST_MUL_LO : scs_pkg::ST_SQ_MUL;
                end
            end
            scs_pkg::ST_SQ_MUL:    n_state = scs_pkg::ST_ACC;
            scs_pkg::ST_ACC:       n_state = r_last ? scs_pkg::ST_FIN : scs_pkg::ST_IDLE;
            scs_pkg::ST_FIN: begin
                n_state = (r_count == '0) ? scs_pkg::ST_IDLE : scs_pkg::ST_MEAN_GO;
            end
            scs_pkg::ST_MEAN_GO:   n_state = scs_pkg::ST_MEAN_WAIT;
            scs_pkg::ST_MEAN_WAIT: begin
                if (w_unit_rsp.done) begin
                    n_state = scs_pkg::ST_MSQ_GO;
                end
            end
            scs_pkg::ST_MSQ_GO:    n_state = scs_pkg::ST_MSQ_WAIT;
            scs_pkg::ST_MSQ_WAIT: begin
                if (w_unit_rsp.done) begin
                    n_state = scs_pkg::ST_MSQ_MUL;
                end
            end
            scs_pkg::ST_MSQ_MUL:   n_state = scs_pkg::ST_VAR;
            scs_pkg::ST_VAR:       n_state = scs_pkg::ST_SQRT_GO;
            scs_pkg::ST_SQRT_GO:   n_state = scs_pkg::ST_SQRT_WAIT;
            scs_pkg::ST_SQRT_WAIT: begin
                if (w_unit_rsp.done) begin
                    n_state = scs_pkg::ST_DENOM;
                end
            end
            scs_pkg::ST_DENOM: begin
                n_state = (r_denom == '0) ? scs_pkg::ST_IDLE : scs_pkg::ST_GAIN_GO;
            end
            scs_pkg::ST_GAIN_GO:   n_state = scs_pkg::ST_GAIN_WAIT;
            scs_pkg::ST_GAIN_WAIT: begin
                if (w_unit_rsp.done) begin
                    n_state = scs_pkg::ST_IDLE;
                end
            end
            scs_pkg::ST_MUL_LO:    n_state = scs_pkg::ST_MUL_HI;
            scs_pkg::ST_MUL_HI:    n_state = scs_pkg::ST_OUT;
            scs_pkg::ST_OUT: begin
                if (w_out_load) begin
                    n_state = scs_pkg::ST_IDLE;
                end
            end
            default:               n_state = scs_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_in_stall       = 1'b1;
        w_mul_en         = 1'b0;
        w_clear          = 1'b0;
        w_out_load       = 1'b0;
        w_unit_req.start = 1'b0;
        w_unit_req.op    = scs_pkg::UOP_DIV;
        case (r_state)
            scs_pkg::ST_IDLE:      w_in_stall = 1'b0;
            scs_pkg::ST_SQ_MUL,
            scs_pkg::ST_MSQ_MUL,
            scs_pkg::ST_MUL_LO,
            scs_pkg::ST_MUL_HI:    w_mul_en = 1'b1;
            scs_pkg::ST_FIN:       w_clear = (r_count == '0);
            scs_pkg::ST_MEAN_GO,
            scs_pkg::ST_MSQ_GO,
            scs_pkg::ST_GAIN_GO:   w_unit_req.start = 1'b1;
            scs_pkg::ST_SQRT_GO: begin
                w_unit_req.start = 1'b1;
                w_unit_req.op    = scs_pkg::UOP_SQRT;
            end
            scs_pkg::ST_DENOM:     w_clear = (r_denom == '0);
            scs_pkg::ST_GAIN_WAIT: w_clear = w_unit_rsp.done;
            scs_pkg::ST_OUT:       w_out_load = ~r_out_valid | ~i_out_stall;
            default: ;
        endcase
    end

    // divide and root operands
    always_comb begin
        w_unit_dvd = '0;
        w_unit_dvs = DVS_W'(r_count);
        case (r_state)
            scs_pkg::ST_MEAN_GO: begin
                w_unit_dvd = DVD_W'({r_sum, {FRAC_W{1'b0}}});
            end
            scs_pkg::ST_MSQ_GO: begin
                w_unit_dvd = DVD_W'({r_sq, {scs_pkg::MSQ_FRAC_W{1'b0}}});
            end
            scs_pkg::ST_SQRT_GO: begin
                w_unit_dvd = DVD_W'(r_var);
            end
            scs_pkg::ST_GAIN_GO: begin
                w_unit_dvd = DVD_W'(GAIN_NUM + NUM_W'(r_denom >> 1));
                w_unit_dvs = DVS_W'(r_denom);
            end
            default: ;
        endcase
    end

    // pixel above the latched offset
    assign w_diff = (r_pix > r_offset) ? (r_pix - r_offset) : '0;

    // shared multiplier operands
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            scs_pkg::ST_SQ_MUL: begin
                w_mul_a = MUL_W'(r_pix);
                w_mul_b = MUL_W'(r_pix);
            end
            scs_pkg::ST_MSQ_MUL: begin
                w_mul_a = MUL_W'(r_mean);
                w_mul_b = MUL_W'(r_mean);
            end
            scs_pkg::ST_MUL_LO: begin
                w_mul_a = MUL_W'(w_diff);
                w_mul_b = r_gain[MUL_W-1:0];
            end
            scs_pkg::ST_MUL_HI: begin
                w_mul_a = MUL_W'(w_diff);
                w_mul_b = MUL_W'(r_gain[GAIN_W-1:MUL_W]);
            end
            default: ;
        endcase
    end

    assign w_mul_p = MUL_P_W'(w_mul_a) * MUL_P_W'(w_mul_b);

    // scaled pixel: combine partial products, round half up, saturate
    assign w_prod    = {r_mul[PROD_W-MUL_W-1:0], {MUL_W{1'b0}}} + r_plo;
    assign w_round   = {1'b0, w_prod} + ROUND_HALF;
    assign w_out_sat = |w_round[PROD_W:GAIN_FRAC_BITS+OUT_W];

    // gain saturation
    assign w_gain_sat = |w_unit_q[DVD_W-1:GAIN_W];

    // control and statistics registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scs_pkg::ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_min       <= '1;
            r_max       <= '0;
            r_offset    <= '0;
            r_gain      <= '0;
            r_flat      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // accumulate one statistics word
            if (r_state == scs_pkg::ST_ACC && r_count < CNT_W'(MAX_PIXELS)) begin
                r_count <= r_count + CNT_W'(1);
                r_sum   <= r_sum + SUM_W'(r_pix);
                r_sq    <= r_sq + SQ_W'(r_mul[2*PIX_W-1:0]);
                if (r_pix < r_min) begin
                    r_min <= r_pix;
                end
                if (r_pix > r_max) begin
                    r_max <= r_pix;
                end
            end

            // frame end: offset, gain and flat flag
            if (r_state == scs_pkg::ST_FIN) begin
                r_offset <= r_min;
                if (r_count == '0) begin
                    r_gain <= '0;
                    r_flat <= 1'b1;
                end
            end
            if (r_state == scs_pkg::ST_DENOM && r_denom == '0) begin
                r_gain <= '0;
                r_flat <= 1'b1;
            end
            if (r_state == scs_pkg::ST_GAIN_WAIT && w_unit_rsp.done) begin
                r_gain <= w_gain_sat ? '1 : w_unit_q[GAIN_W-1:0];
                r_flat <= 1'b0;
            end

            // restart the accumulators for the next frame
            if (w_clear) begin
                r_count <= '0;
                r_sum   <= '0;
                r_sq    <= '0;
                r_min   <= '1;
                r_max   <= '0;
            end

            // output register
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (~i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pix  <= i_in_data.pixel_value;
            r_last <= i_in_data.last_pixel;
        end
        if (w_mul_en) begin
            r_mul <= w_mul_p;
        end
        if (r_state == scs_pkg::ST_MUL_HI) begin
            r_plo <= r_mul[PROD_W-1:0];
        end
        if (r_state == scs_pkg::ST_MEAN_WAIT && w_unit_rsp.done) begin
            r_mean <= w_unit_q[scs_pkg::MEAN_W-1:0];
        end
        if (r_state == scs_pkg::ST_MSQ_WAIT && w_unit_rsp.done) begin
            r_var <= w_unit_q[scs_pkg::MSQ_W-1:0];
        end
        if (r_state == scs_pkg::ST_VAR) begin
            r_var <= (r_var >= r_mul) ? (r_var - r_mul) : '0;
        end
        if (r_state == scs_pkg::ST_SQRT_WAIT && w_unit_rsp.done) begin
            r_denom <= DENOM_W'({r_max, {FRAC_W{1'b0}}}) - DENOM_W'(r_mean)
                       + DENOM_W'(w_unit_root);
        end
        if (w_out_load) begin
            r_out_data.scaled_pixel <= w_out_sat ? '1 :
                                       w_round[GAIN_FRAC_BITS+OUT_W-1:GAIN_FRAC_BITS];
            r_out_data.flat_frame   <= r_flat;
        end
    end

    assign o_in_stall  = w_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // pixel count stays within the frame limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PIXELS))
        else $error("pixel count above frame limit");

    // a flat frame always carries zero gain
    a_flat_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flat |-> (r_gain == '0))
        else $error("flat frame with nonzero gain");

    // the unit is started only when free
    a_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_unit_req.start |-> !w_unit_rsp.busy)
        else $error("unit started while busy");

    // unit completion lands in a wait state
    a_unit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_unit_rsp.done |-> (r_state == scs_pkg::ST_MEAN_WAIT ||
                             r_state == scs_pkg::ST_MSQ_WAIT ||
                             r_state == scs_pkg::ST_SQRT_WAIT ||
                             r_state == scs_pkg::ST_GAIN_WAIT))
        else $error("unit done outside a wait state");

    // a new result comes only from the output state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == scs_pkg::ST_OUT))
        else $error("result word raised outside output state");

endmodule

`default_nettype wire

>>> test/stddev_contrast_stretch_tb.sv
// ----------------------------------------------------------------------------
// stddev_contrast_stretch_tb
// Self-checking bench for the two pass contrast stretch. Frames of statistics
// words are followed by runs of scale words. A local predictor keeps its own
// copy of the frame accumulators and the latched offset and gain. It computes
// every stretched word and compares it field by field with what the block
// returns. Both sides idle at random, and the receiver holds off once for a
// long stretch. Some frames wait until all stretched words have come back.
// ----------------------------------------------------------------------------

module stddev_contrast_stretch_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scs_pkg::*;

    localparam int GAIN_FRAC = GAIN_FRAC_BITS_DEF;
    localparam int PIXEL_CAP = MAX_PIXELS_DEF;
    localparam logic FUNC_STATS = 1'b0;
    localparam logic FUNC_SCALE = 1'b1;
    localparam logic [GAIN_W-1:0] GAIN_CEIL = '1;

    localparam int WORD_TARGET      = 550;
    localparam int QUIET_TAIL       = 60;     // words at the end with no idling
    localparam int HOLD_AT          = 150;    // long receiver hold starts here
    localparam int HOLD_LEN         = 400;
    localparam int FRAME_END_CYCLES = 330;    // frame end work plus margin
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int REPORT_MAX       = 10;

    typedef struct {
        t_in_word word;
        bit       drain_first;   // wait for all stretched words before sending
    } t_feed;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_data;

    t_feed     feed_q[$];
    t_out_word stretch_q[$];

    int words_in      = 0;
    int words_total   = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int cycles        = 0;
    int mismatches    = 0;
    int words_checked = 0;
    int frames_closed = 0;
    int flat_closes   = 0;
    int saturated     = 0;

    // predictor state
    logic [24:0]       cnt_pix;
    logic [40:0]       sum_pix;
    logic [56:0]       sum_sq;
    logic [PIX_W-1:0]  min_pix;
    logic [PIX_W-1:0]  max_pix;
    logic [PIX_W-1:0]  lvl_offset;
    logic [GAIN_W-1:0] lvl_gain;
    logic              lvl_flat;

    stddev_contrast_stretch dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit quiet_phase();
        return words_in >= words_total - QUIET_TAIL;
    endfunction

    // integer square root, bit by bit
    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] b;
        rem  = v;
        root = '0;
        b    = 64'h4000_0000_0000_0000;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    task automatic stats_clear();
        cnt_pix = '0;
        sum_pix = '0;
        sum_sq  = '0;
        min_pix = '1;
        max_pix = '0;
    endtask

    // mean, deviation and gain at frame end
    task automatic frame_close();
        logic [63:0] n;
        logic [63:0] mean16;
        logic [63:0] qint;
        logic [63:0] qrem;
        logic [63:0] meansq;
        logic [63:0] msq;
        logic [63:0] var32;
        logic [63:0] sd16;
        logic [63:0] denom;
        logic [63:0] gain;
        n = 64'(cnt_pix);
        lvl_offset = min_pix;
        frames_closed++;
        if (n == 0) begin
            lvl_gain = '0;
            lvl_flat = 1'b1;
            flat_closes++;
        end else begin
            mean16 = (64'(sum_pix) << 16) / n;
            qint   = 64'(sum_sq) / n;
            qrem   = 64'(sum_sq) % n;
            meansq = (qint << 32) + ((qrem << 32) / n);
            msq    = mean16 * mean16;
            var32  = (meansq >= msq) ? meansq - msq : 64'd0;
            sd16   = isqrt64(var32);
            denom  = (64'(max_pix) << 16) - mean16 + sd16;
            if (denom == 0) begin
                lvl_gain = '0;
                lvl_flat = 1'b1;
                flat_closes++;
            end else begin
                gain = ((64'd255 << (GAIN_FRAC + 16)) + (denom >> 1)) / denom;
                lvl_gain = (gain > 64'(GAIN_CEIL)) ? GAIN_CEIL : gain[GAIN_W-1:0];
                lvl_flat = 1'b0;
            end
        end
    endtask

    // statistics word: accumulate, close the frame on its last pixel
    task automatic stats_take(logic [PIX_W-1:0] p, logic last);
        if (cnt_pix < PIXEL_CAP) begin
            cnt_pix = cnt_pix + 1'b1;
            sum_pix = sum_pix + 41'(p);
            sum_sq  = sum_sq + 57'(p) * 57'(p);
            if (p < min_pix) min_pix = p;
            if (p > max_pix) max_pix = p;
        end
        if (last) begin
            frame_close();
            stats_clear();
        end
    endtask

    function automatic t_out_word stretch_pixel(logic [PIX_W-1:0] p);
        t_out_word   r;
        logic [63:0] diff;
        logic [63:0] rnd;
        r = '0;
        if (lvl_flat) begin
            r.flat_frame = 1'b1;
        end else begin
            diff = (p > lvl_offset) ? 64'(p - lvl_offset) : 64'd0;
            rnd  = (diff * 64'(lvl_gain) + (64'd1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
            r.scaled_pixel = (rnd > 64'(OUT_MAX)) ? '1 : rnd[OUT_W-1:0];
        end
        return r;
    endfunction

    task automatic add_word(logic func, logic [PIX_W-1:0] p, logic last, bit drain);
        t_feed f;
        f.word.func        = func;
        f.word.pixel_value = p;
        f.word.last_pixel  = last;
        f.drain_first      = drain;
        feed_q.push_back(f);
    endtask

    // one random frame: statistics words with an occasional stray scale word, then a run of scale words
    task automatic gen_frame(bit drain);
        int               kind;
        int               span;
        int               n_pix;
        int               n_scale;
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] hi;
        kind = $urandom_range(9, 0);
        case ($urandom_range(3, 0))
            0: span = 65535;
            1: span = $urandom_range(65535, 256);
            2: span = $urandom_range(255, 1);
            default: span = $urandom_range(15, 0);
        endcase
        lo = 16'($urandom_range(65535 - span, 0));
        hi = lo + 16'(span);
        if (kind == 1) hi = lo;
        n_pix = (kind == 0) ? 1 : $urandom_range(12, 2);
        for (int i = 0; i < n_pix; i++) begin
            // stray scale word in the middle of the statistics pass
            if ($urandom_range(9, 0) == 0)
                add_word(FUNC_SCALE, 16'($urandom), 1'($urandom), 1'b0);
            add_word(FUNC_STATS, 16'($urandom_range(hi, lo)), i == n_pix - 1,
                     drain && i == 0);
        end
        n_scale = $urandom_range(18, 3);
        for (int i = 0; i < n_scale; i++) begin
            if ($urandom_range(3, 0) == 0)
                add_word(FUNC_SCALE, 16'($urandom), 1'($urandom), 1'b0);
            else
                add_word(FUNC_SCALE, 16'($urandom_range(hi, lo)), 1'($urandom), 1'b0);
        end
    endtask

    // driver: offers pending words, predicts on each accepted one
    always @(posedge clk) begin
        t_feed nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
            stats_clear();
            lvl_offset = '0;
            lvl_gain   = '0;
            lvl_flat   = 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                words_in <= words_in + 1;
                if (in_data.func == FUNC_STATS) begin
                    stats_take(in_data.pixel_value, in_data.last_pixel);
                end else begin
                    stretch_q.push_back(stretch_pixel(in_data.pixel_value));
                    if (!stretch_q[$].flat_frame && stretch_q[$].scaled_pixel == OUT_MAX)
                        saturated++;
                end
            end
            // a stalled word stays as it is
            if (!(in_valid && in_stall)) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (feed_q.size() != 0 &&
                             !(feed_q[0].drain_first && stretch_q.size() != 0)) begin
                    nxt = feed_q.pop_front();
                    in_valid <= 1'b1;
                    in_data  <= nxt.word;
                    if (!quiet_phase() && $urandom_range(5, 0) == 0)
                        gap_left <= $urandom_range(3, 1);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold, once
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && words_in >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // monitor: checks each accepted result word, drives the receiver stall
    always @(posedge clk) begin
        t_out_word want;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (stretch_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result word: scaled_pixel %0d flat_frame %0b",
                                 out_data.scaled_pixel, out_data.flat_frame);
                end else begin
                    want = stretch_q.pop_front();
                    words_checked++;
                    if (out_data.scaled_pixel !== want.scaled_pixel ||
                        out_data.flat_frame !== want.flat_frame) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("word %0d: scaled_pixel exp %0d got %0d, flat_frame exp %0b got %0b",
                                     words_checked, want.scaled_pixel, out_data.scaled_pixel,
                                     want.flat_frame, out_data.flat_frame);
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end else if (!quiet_phase() && $urandom_range(6, 0) == 0) begin
                stall_left <= $urandom_range(2, 0);
                out_stall  <= 1'b1;
            end else begin
                out_stall <= (hold_left != 0);
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycles, stretch_q.size());
            $display("stddev_contrast_stretch verification failed");
            $finish;
        end
    end

    initial begin
        // scale before any statistics, last_pixel ignored in scale pass
        add_word(FUNC_SCALE, 16'd0, 1'b0, 1'b0);
        add_word(FUNC_SCALE, 16'hFFFF, 1'b1, 1'b0);
        // single pixel frame is flat
        add_word(FUNC_STATS, 16'd777, 1'b1, 1'b0);
        add_word(FUNC_SCALE, 16'd40000, 1'b0, 1'b0);
        // flat frame of equal pixels
        add_word(FUNC_STATS, 16'd1234, 1'b0, 1'b0);
        add_word(FUNC_STATS, 16'd1234, 1'b1, 1'b0);
        add_word(FUNC_SCALE, 16'd1234, 1'b0, 1'b0);
        // full range frame
        add_word(FUNC_STATS, 16'd0, 1'b0, 1'b0);
        add_word(FUNC_STATS, 16'hFFFF, 1'b1, 1'b0);
        add_word(FUNC_SCALE, 16'd0, 1'b0, 1'b0);
        add_word(FUNC_SCALE, 16'hFFFF, 1'b0, 1'b0);
        add_word(FUNC_SCALE, 16'h8000, 1'b1, 1'b0);
        // high minimum, scale pixel below it
        add_word(FUNC_STATS, 16'd60000, 1'b0, 1'b0);
        add_word(FUNC_STATS, 16'd60010, 1'b0, 1'b0);
        add_word(FUNC_STATS, 16'hFFFF, 1'b1, 1'b0);
        add_word(FUNC_SCALE, 16'd100, 1'b0, 1'b0);
        add_word(FUNC_SCALE, 16'hFFFF, 1'b0, 1'b0);
        // one low outlier: mean minus deviation above minimum, output saturates
        add_word(FUNC_STATS, 16'd0, 1'b0, 1'b1);
        for (int i = 0; i < 5; i++)
            add_word(FUNC_STATS, 16'd60000, i == 4, 1'b0);
        add_word(FUNC_SCALE, 16'd60000, 1'b0, 1'b0);

        // random frames, the first one after a full drain
        gen_frame(1'b1);
        while (feed_q.size() < WORD_TARGET)
            gen_frame($urandom_range(4, 0) == 0);
        words_total = feed_q.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (words_in < words_total || stretch_q.size() != 0)
            @(posedge clk);
        repeat (FRAME_END_CYCLES) @(posedge clk);

        $display("%0d words sent, %0d stretched words checked, %0d mismatches",
                 words_in, words_checked, mismatches);
        $display("%0d frames closed (%0d flat), %0d saturated outputs",
                 frames_closed, flat_closes, saturated);
        if (mismatches == 0 && stretch_q.size() == 0) begin
            $display("stddev_contrast_stretch verification clean");
        end else begin
            $display("stddev_contrast_stretch verification failed");
        end
        $finish;
    end

endmodule
